FILE: src/ldh_pkg.sv
// Shared types and constants for the latency delta histogram.
// No dependencies.
package ldh_pkg;

  localparam logic [1:0] FUNC_ENTRY = 2'd0;
  localparam logic [1:0] FUNC_RDBKT = 2'd1;
  localparam logic [1:0] FUNC_RDSTAT = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam logic [1:0] KIND_BINNED = 2'd0;
  localparam logic [1:0] KIND_MISSING = 2'd1;
  localparam logic [1:0] KIND_NOTHING = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  localparam logic [1:0] REG_MIN = 2'd0;
  localparam logic [1:0] REG_MAX = 2'd1;
  localparam logic [1:0] REG_WIDTH = 2'd2;
  localparam logic [1:0] REG_COUNT = 2'd3;

  localparam logic [14:0] ST_COUNT = 15'd0;
  localparam logic [14:0] ST_SUM = 15'd1;
  localparam logic [14:0] ST_SUMSQ = 15'd2;
  localparam logic [14:0] ST_MISSB = 15'd3;
  localparam logic [14:0] ST_MISSA = 15'd4;
  localparam logic [14:0] ST_UNDER = 15'd5;

  localparam int HIT_LIMIT = 8;

  // controller -> datapath
  typedef struct packed {
    logic entry;      // absorb history entry
    logic finish;     // record end: classify and update statistics
    logic div_start;
    logic div_step;
    logic bin_read;   // read bucket at computed index
    logic bin_write;  // write incremented bucket
    logic rd_bucket;  // read bucket request
    logic rd_stat;
    logic clr_step;
    logic load_out;   // capture result into output register
  } ldh_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic complete;   // record had both timestamps
    logic div_done;
    logic clr_done;
  } ldh_stat_t;

endpackage

FILE: src/latency_delta_histogram.sv
// Top level of the latency delta histogram.
// Depends on ldh_pkg, ldh_ctrl and ldh_datapath.
//
// After reset the bucket memory is cleared, one bucket a cycle, and no request
// is taken meanwhile. A history entry that is not the last of its record is
// absorbed with no result; a read passes through READ; a record end with one
// timestamp missing is finished in FINISH; a complete record runs the
// bit-serial 33-step divider by the bucket width and the read-modify-write
// of the bucket memory. One request is in flight at a time.
module latency_delta_histogram #(
  parameter int NUM_BUCKETS = 32768,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [63:0] entry_ts,
  input  logic        entry_file,
  input  logic        last_entry,
  input  logic [7:0]  hit_count,
  input  logic [14:0] read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [63:0] delay,
  output logic [14:0] bucket,
  output logic [63:0] read_value
);
  ldh_pkg::ldh_cmd_t cmd;
  ldh_pkg::ldh_stat_t stat;

  ldh_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .func, .last_entry,
    .out_valid, .out_ready, .stat, .cmd
  );

  ldh_datapath #(.NUM_BUCKETS(NUM_BUCKETS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_index, .cfg_data,
    .func, .entry_ts, .entry_file, .last_entry, .hit_count, .read_index,
    .kind, .delay, .bucket, .read_value
  );
endmodule

FILE: src/ldh_datapath.sv
// Datapath: history capture, statistics, divider, bucket memory, output register.
// Depends on ldh_pkg.
module ldh_datapath #(
  parameter int NUM_BUCKETS = 32768,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  ldh_pkg::ldh_cmd_t  cmd,
  output ldh_pkg::ldh_stat_t stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         func,
  input  logic [63:0]        entry_ts,
  input  logic               entry_file,
  input  logic               last_entry,
  input  logic [7:0]         hit_count,
  input  logic [14:0]        read_index,
  output logic [1:0]         kind,
  output logic [63:0]        delay,
  output logic [14:0]        bucket,
  output logic [63:0]        read_value
);
  localparam int AW = $clog2(NUM_BUCKETS);
  localparam int PW = $clog2(HISTORY_DEPTH + 1);
  localparam int CW = $clog2(NUM_BUCKETS + 1);
  localparam logic [47:0] MAX48 = '1;

  logic signed [31:0] hist_min, hist_max;
  logic [30:0] bucket_width;
  logic [15:0] bucket_count;

  logic [31:0] mem [NUM_BUCKETS];
  logic [31:0] mem_q;
  logic [AW-1:0] clr_addr;

  logic [63:0] sample_count, delay_square_sum;
  logic signed [63:0] delay_sum;
  logic [47:0] missing_in_b, missing_in_a, under_eight_count;
  logic [63:0] first_stamp, other_stamp;
  logic first_file, other_found;
  logic [PW-1:0] entry_position;

  // request fields held after the handshake
  logic [1:0] func_q;
  logic [7:0] hits_q;
  logic [14:0] ridx_q;

  logic [63:0] du, ta, tb, other;
  logic signed [63:0] d, hcl;
  logic [32:0] hoff;
  logic [32:0] rem;
  logic [32:0] quo;
  logic [5:0] div_cnt;
  logic [30:0] wdiv;
  logic [AW-1:0] idx;
  logic [63:0] mag, sq;
  logic [64:0] sqsum;
  logic signed [64:0] dsum;
  logic [CW-1:0] cnt_lim;
  logic [PW-1:0] pos_next;
  logic [63:0] stat_val;
  logic take_other;

  always_comb begin
    other = other_found ? other_stamp : 64'd0;
    ta = first_file ? other : first_stamp;
    tb = first_file ? first_stamp : other;
    du = tb - ta;
    d = $signed(du);
    hcl = (d > 64'(hist_max)) ? 64'(hist_max) : d;
    hcl = (hcl < 64'(hist_min)) ? 64'(hist_min) : hcl;
    hoff = 33'(hcl - 64'(hist_min));
    mag = du[63] ? (64'd0 - du) : du;
    sq = mag[31:0] * mag[31:0];
    sqsum = {1'b0, delay_square_sum} + {1'b0, sq};
    dsum = 65'(delay_sum) + 65'(d);
    wdiv = (bucket_width == 31'd0) ? 31'd1 : bucket_width;
    if (bucket_count == 16'd0) cnt_lim = CW'(1);
    else if (32'(bucket_count) > NUM_BUCKETS) cnt_lim = CW'(NUM_BUCKETS);
    else cnt_lim = CW'(bucket_count);
    if (quo >= 33'(cnt_lim)) idx = AW'(cnt_lim - CW'(1));
    else idx = AW'(quo);
    take_other = (32'(entry_position) < HISTORY_DEPTH) &&
                 (8'(entry_position) < hit_count) && !other_found &&
                 (entry_file != first_file);
    pos_next = (32'(entry_position) < HISTORY_DEPTH) ? entry_position + PW'(1)
                                                      : entry_position;
    case (ridx_q)
      ldh_pkg::ST_COUNT: stat_val = sample_count;
      ldh_pkg::ST_SUM: stat_val = delay_sum;
      ldh_pkg::ST_SUMSQ: stat_val = delay_square_sum;
      ldh_pkg::ST_MISSB: stat_val = 64'(missing_in_b);
      ldh_pkg::ST_MISSA: stat_val = 64'(missing_in_a);
      ldh_pkg::ST_UNDER: stat_val = 64'(under_eight_count);
      default: stat_val = 64'd0;
    endcase
  end

  assign stat.complete = (ta != 64'd0) && (tb != 64'd0);
  assign stat.div_done = (div_cnt == 6'd0);
  assign stat.clr_done = (clr_addr == AW'(NUM_BUCKETS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_min <= -32'sd1000000;
      hist_max <= 32'sd1000000;
      bucket_width <= 31'd100;
      bucket_count <= 16'd20000;
    end else if (cfg_we) begin
      case (cfg_index)
        ldh_pkg::REG_MIN: hist_min <= cfg_data;
        ldh_pkg::REG_MAX: hist_max <= cfg_data;
        ldh_pkg::REG_WIDTH: bucket_width <= cfg_data[30:0];
        ldh_pkg::REG_COUNT: bucket_count <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.entry || cmd.rd_bucket || cmd.rd_stat) begin
      func_q <= func;
      hits_q <= hit_count;
      ridx_q <= read_index;
    end
  end

  // bucket memory, cleared by a sweep after reset
  always_ff @(posedge clk) begin
    if (cmd.clr_step) mem[clr_addr] <= 32'd0;
    else if (cmd.bin_write) mem[idx] <= (mem_q == '1) ? mem_q : mem_q + 32'd1;
    if (cmd.bin_read) mem_q <= mem[idx];
    else if (cmd.rd_bucket) mem_q <= mem[AW'(read_index)];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr_step && !stat.clr_done) clr_addr <= clr_addr + AW'(1);
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      quo <= hoff;
      div_cnt <= 6'd33;
    end else if (cmd.div_step && div_cnt != 6'd0) begin
      logic [33:0] trial;
      trial = {rem, quo[32]} - {3'd0, wdiv};
      if (!trial[33]) begin
        rem <= trial[32:0];
        quo <= {quo[31:0], 1'b1};
      end else begin
        rem <= {rem[31:0], quo[32]};
        quo <= {quo[31:0], 1'b0};
      end
      div_cnt <= div_cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      delay_sum <= '0;
      delay_square_sum <= '0;
      missing_in_a <= '0;
      missing_in_b <= '0;
      under_eight_count <= '0;
      first_stamp <= '0;
      other_stamp <= '0;
      first_file <= 1'b0;
      other_found <= 1'b0;
      entry_position <= '0;
    end else begin
      if (cmd.entry) begin
        if (entry_position == '0) begin
          first_stamp <= entry_ts;
          first_file <= entry_file;
          other_found <= 1'b0;
          other_stamp <= '0;
        end else if (take_other) begin
          other_found <= 1'b1;
          other_stamp <= entry_ts;
        end
        entry_position <= last_entry ? '0 : pos_next;
      end
      if (cmd.finish) begin
        if (stat.complete) begin
          if (sample_count != '1) sample_count <= sample_count + 64'd1;
          if (dsum > 65'sh0_7FFF_FFFF_FFFF_FFFF) delay_sum <= 64'sh7FFF_FFFF_FFFF_FFFF;
          else if (dsum < -65'sh0_8000_0000_0000_0000)
            delay_sum <= 64'sh8000_0000_0000_0000;
          else delay_sum <= dsum[63:0];
          if (mag[63:32] != 32'd0 || sqsum[64]) delay_square_sum <= '1;
          else delay_square_sum <= sqsum[63:0];
        end else if (32'(hits_q) < ldh_pkg::HIT_LIMIT) begin
          if (first_file && !other_found) begin
            if (missing_in_a != MAX48) missing_in_a <= missing_in_a + 48'd1;
          end else if (missing_in_b != MAX48) missing_in_b <= missing_in_b + 48'd1;
        end
        if (32'(hits_q) < ldh_pkg::HIT_LIMIT && under_eight_count != MAX48)
          under_eight_count <= under_eight_count + 48'd1;
      end
    end
  end

  // output register; finish comes after the record's last entry was absorbed
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kind <= ldh_pkg::KIND_NOTHING;
      delay <= '0;
      bucket <= '0;
      read_value <= '0;
      if (func_q == ldh_pkg::FUNC_RDBKT) begin
        kind <= ldh_pkg::KIND_READ;
        read_value <= (32'(ridx_q) < NUM_BUCKETS) ? 64'(mem_q) : 64'd0;
      end else if (func_q == ldh_pkg::FUNC_RDSTAT) begin
        kind <= ldh_pkg::KIND_READ;
        read_value <= stat_val;
      end else if (stat.complete) begin
        kind <= ldh_pkg::KIND_BINNED;
        delay <= du;
        bucket <= 15'(idx);
      end else if (32'(hits_q) < ldh_pkg::HIT_LIMIT) begin
        kind <= ldh_pkg::KIND_MISSING;
      end
    end
  end
endmodule

FILE: src/ldh_ctrl.sv
// Controller state machine for the latency delta histogram.
// Depends on ldh_pkg.
module ldh_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic               last_entry,
  output logic               out_valid,
  input  logic               out_ready,
  input  ldh_pkg::ldh_stat_t stat,
  output ldh_pkg::ldh_cmd_t  cmd
);
  typedef enum logic [2:0] {
    CLEAR, IDLE, READ, DIVIDE, BIN_RD, BIN_WR, FINISH
  } state_t;
  state_t state;

  logic acc;
  assign in_ready = (state == IDLE) && !out_valid;
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.clr_step = (state == CLEAR);
    cmd.entry = acc && (func == ldh_pkg::FUNC_ENTRY);
    cmd.rd_bucket = acc && (func == ldh_pkg::FUNC_RDBKT);
    cmd.rd_stat = acc && (func == ldh_pkg::FUNC_RDSTAT);
    cmd.div_start = (state == FINISH);
    cmd.div_step = (state == DIVIDE);
    cmd.bin_read = (state == DIVIDE) && stat.div_done;
    cmd.bin_write = (state == BIN_WR);
    cmd.finish = (state == BIN_WR) || ((state == FINISH) && !stat.complete);
    cmd.load_out = (state == READ) || cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        CLEAR: if (stat.clr_done) state <= IDLE;
        IDLE: if (acc) begin
          if (func == ldh_pkg::FUNC_RDBKT || func == ldh_pkg::FUNC_RDSTAT) state <= READ;
          else if (func == ldh_pkg::FUNC_ENTRY && last_entry) state <= FINISH;
        end
        READ: begin
          out_valid <= 1'b1;
          state <= IDLE;
        end
        FINISH: if (stat.complete) state <= DIVIDE;
                else begin
                  out_valid <= 1'b1;
                  state <= IDLE;
                end
        DIVIDE: if (stat.div_done) state <= BIN_RD;
        BIN_RD: state <= BIN_WR;
        BIN_WR: begin
          out_valid <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) state == CLEAR |-> !in_ready)
    else $error("request taken during clear");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("request taken with result pending");
  assert property (@(posedge clk) disable iff (rst) state == BIN_WR |=> out_valid)
    else $error("binned result not shown");
endmodule
